@@ hw/rtl/vertex_layout_validator_unit_assert.svh @@
// Assertion macros shared by the vertex layout validator checker.
`ifndef VERTEX_LAYOUT_VALIDATOR_UNIT_ASSERT_SVH
`define VERTEX_LAYOUT_VALIDATOR_UNIT_ASSERT_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define VLV_ASSERT_CLK(lbl, clk_sig, rstn_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
    else $error("vertex layout validator assertion failed");

// Same, on the default clock and reset names.
`define VLV_ASSERT(lbl, prop) `VLV_ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

@@ hw/rtl/vlv_pkg.sv @@
// Types, codes and constants of the vertex layout validator.
package vlv_pkg;

  localparam int MAX_ATTRIBUTES_DEF = 16;
  localparam int STRIDE_W  = 16;
  localparam int TOTAL_W   = 8;
  localparam int LOC_W     = 8;
  localparam int FMT_W     = 3;
  localparam int OFF_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int AIDX_W    = 4;
  localparam int SIZE_W    = 5;
  localparam int START_W   = 12;
  localparam int END_W     = 13;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [STRIDE_W-1:0] STRIDE_MAX = 16'd2048;

  localparam logic [CFG_ADDR_W-1:0] REG_STRIDE     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_ATTR_TOTAL = 1'b1;

  localparam logic [FMT_W-1:0] FMT_FLOAT1 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_FLOAT2 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_FLOAT3 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_FLOAT4 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_UBYTE4 = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STRIDE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COUNT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FIRST   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ATTR    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic set_err;
    logic err_ovl;
    logic record;
    logic scan_clr;
    logic scan_inc;
    logic rd;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic held;
    logic pre_fail;
    logic first_item;
    logic hit;
    logic scan_last;
  } stat_t;

  // Element size in bytes; zero marks an unsupported format.
  function automatic logic [SIZE_W-1:0] elem_size(input logic [FMT_W-1:0] fmt);
    logic [SIZE_W-1:0] sz;
    case (fmt)
      FMT_FLOAT1: sz = 5'd4;
      FMT_FLOAT2: sz = 5'd8;
      FMT_FLOAT3: sz = 5'd12;
      FMT_FLOAT4: sz = 5'd16;
      FMT_UBYTE4: sz = 5'd4;
      default:    sz = 5'd0;
    endcase
    return sz;
  endfunction

endpackage

@@ hw/rtl/vertex_layout_validator_unit.sv @@
// Top level of the vertex layout validator.
// The unit checks one vertex layout at a time. Stride and attribute count are
// written through the cfg_ port (index 0 stride, index 1 count); the user is
// to write them only while the unit is idle, which the unit does not enforce.
// Each attribute is offered on the in_ ports with start; the transfer happens
// at a rising edge where start is high and busy is low. Every attribute yields
// one result on the out_ ports, shown for exactly one cycle with out_valid: the
// sticky first error of the layout, the attribute's position and a layout_done
// flag on the last attribute, which also clears the layout state. The receiver
// cannot stall; it must take each result as shown. Busy stays high while an
// item is checked; the result strobe appears in the cycle busy falls, and the
// next transfer can be taken at the edge that ends that cycle, so a new item
// is taken only once the last has its result. The single overlap comparator
// visits the earlier stored ranges (0 to MAX_ATTRIBUTES-1 of them) one at a
// time, in a read and a compare state, through the registered read port of
// the range memory. The first item of a layout, an item that fails the stride,
// count or attribute checks and an item arriving after an error compare no
// ranges. Reset clears the layout state and both registers; the range memory
// needs no clearing since only entries of the current layout are ever read.
module vertex_layout_validator_unit #(
  parameter int MAX_ATTRIBUTES = vlv_pkg::MAX_ATTRIBUTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [vlv_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [vlv_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           start,
  output logic                           busy,
  input  logic [vlv_pkg::LOC_W-1:0]      in_attr_location,
  input  logic [vlv_pkg::FMT_W-1:0]      in_attr_format,
  input  logic [vlv_pkg::OFF_W-1:0]      in_attr_offset,
  output logic                           out_valid,
  output logic [vlv_pkg::STATUS_W-1:0]   out_status,
  output logic [vlv_pkg::AIDX_W-1:0]     out_attr_index,
  output logic                           out_layout_done
);

  vlv_pkg::cmd_t  cmd;
  vlv_pkg::stat_t stat;

  vlv_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  vlv_datapath #(
    .MAX_ATTRIBUTES (MAX_ATTRIBUTES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_attr_location (in_attr_location),
    .in_attr_format   (in_attr_format),
    .in_attr_offset   (in_attr_offset),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_attr_index   (out_attr_index),
    .out_layout_done  (out_layout_done)
  );

endmodule

@@ hw/rtl/vlv_ctrl.sv @@
// Controller state machine of the vertex layout validator.
module vlv_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  vlv_pkg::stat_t stat,
  output vlv_pkg::cmd_t  cmd,
  output logic          busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_CMP,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.held) begin
          state_nxt = S_EMIT;
        end else if (stat.pre_fail) begin
          cmd.set_err = 1'b1;
          state_nxt   = S_EMIT;
        end else if (stat.first_item) begin
          cmd.record = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (stat.hit) begin
          cmd.set_err = 1'b1;
          cmd.err_ovl = 1'b1;
          state_nxt   = S_EMIT;
        end else if (stat.scan_last) begin
          cmd.record = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = S_READ;
        end
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

@@ hw/rtl/vlv_datapath.sv @@
// Datapath of the vertex layout validator: registers, checks and range store.
module vlv_datapath #(
  parameter int MAX_ATTRIBUTES = vlv_pkg::MAX_ATTRIBUTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [vlv_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [vlv_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [vlv_pkg::LOC_W-1:0]       in_attr_location,
  input  logic [vlv_pkg::FMT_W-1:0]       in_attr_format,
  input  logic [vlv_pkg::OFF_W-1:0]       in_attr_offset,
  input  vlv_pkg::cmd_t                   cmd,
  output vlv_pkg::stat_t                  stat,
  output logic                            out_valid,
  output logic [vlv_pkg::STATUS_W-1:0]    out_status,
  output logic [vlv_pkg::AIDX_W-1:0]      out_attr_index,
  output logic                            out_layout_done
);

  localparam int IDX_W = (MAX_ATTRIBUTES > 1) ? $clog2(MAX_ATTRIBUTES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ATTRIBUTES - 1);
  localparam logic [vlv_pkg::TOTAL_W-1:0] TOTAL_MAX = vlv_pkg::TOTAL_W'(MAX_ATTRIBUTES);
  localparam logic [vlv_pkg::LOC_W-1:0] LOC_LIMIT = vlv_pkg::LOC_W'(MAX_ATTRIBUTES);

  logic [vlv_pkg::STRIDE_W-1:0] stride_r;
  logic [vlv_pkg::TOTAL_W-1:0]  total_r;

  logic [vlv_pkg::LOC_W-1:0]    loc_r;
  logic [vlv_pkg::FMT_W-1:0]    fmt_r;
  logic [vlv_pkg::OFF_W-1:0]    off_r;

  logic [MAX_ATTRIBUTES-1:0]    used_r;
  logic [IDX_W-1:0]             count_r;
  logic [vlv_pkg::STATUS_W-1:0] err_r;
  logic [IDX_W-1:0]             scan_r;

  logic [vlv_pkg::START_W-1:0]  start_mem [MAX_ATTRIBUTES];
  logic [vlv_pkg::END_W-1:0]    end_mem   [MAX_ATTRIBUTES];
  logic [vlv_pkg::START_W-1:0]  rd_start_r;
  logic [vlv_pkg::END_W-1:0]    rd_end_r;

  logic                         out_valid_r;
  logic [vlv_pkg::STATUS_W-1:0] out_status_r;
  logic [vlv_pkg::AIDX_W-1:0]   out_index_r;
  logic                         out_done_r;

  logic [vlv_pkg::SIZE_W-1:0]   size;
  logic [vlv_pkg::OFF_W:0]      off_end;
  logic                         loc_ok;
  logic                         loc_taken;
  logic                         stride_bad;
  logic                         count_bad;
  logic                         first_bad;
  logic                         attr_bad;
  logic [vlv_pkg::STATUS_W-1:0] pre_code;
  logic                         done;

  always_comb begin
    size      = vlv_pkg::elem_size(fmt_r);
    off_end   = {1'b0, off_r} + (vlv_pkg::OFF_W + 1)'(size);
    loc_ok    = (loc_r < LOC_LIMIT);
    loc_taken = loc_ok ? used_r[loc_r[IDX_W-1:0]] : 1'b0;

    stride_bad = (stride_r == '0) || (stride_r > vlv_pkg::STRIDE_MAX) ||
                 (stride_r[1:0] != 2'b00);
    count_bad  = (total_r == '0) || (total_r > TOTAL_MAX);
    first_bad  = (count_r == '0) &&
                 ((loc_r != '0) || (fmt_r != vlv_pkg::FMT_FLOAT3) || (off_r != '0));
    // The end is one bit wider than the offset, so the end compare never wraps.
    attr_bad   = !loc_ok || loc_taken || (size == '0) || (off_r[1:0] != 2'b00) ||
                 (off_r > stride_r) || (off_end > {1'b0, stride_r});

    if (stride_bad) begin
      pre_code = vlv_pkg::ST_STRIDE;
    end else if (count_bad) begin
      pre_code = vlv_pkg::ST_COUNT;
    end else if (first_bad) begin
      pre_code = vlv_pkg::ST_FIRST;
    end else if (attr_bad) begin
      pre_code = vlv_pkg::ST_ATTR;
    end else begin
      pre_code = vlv_pkg::ST_OK;
    end

    done = (total_r == '0) ||
           ((vlv_pkg::TOTAL_W'(count_r) + vlv_pkg::TOTAL_W'(1)) == total_r) ||
           (count_r == IDX_LAST);

    stat.held       = (err_r != vlv_pkg::ST_OK);
    stat.pre_fail   = (pre_code != vlv_pkg::ST_OK);
    stat.first_item = (count_r == '0);
    stat.hit        = ((vlv_pkg::OFF_W + 1)'(off_r) < (vlv_pkg::OFF_W + 1)'(rd_end_r)) &&
                      ((vlv_pkg::OFF_W + 1)'(rd_start_r) < off_end);
    stat.scan_last  = (({1'b0, scan_r} + (IDX_W + 1)'(1)) == {1'b0, count_r});
  end

  // Configuration and item registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= '0;
      total_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        vlv_pkg::REG_STRIDE:     stride_r <= cfg_wdata;
        vlv_pkg::REG_ATTR_TOTAL: total_r  <= cfg_wdata[vlv_pkg::TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      loc_r <= in_attr_location;
      fmt_r <= in_attr_format;
      off_r <= in_attr_offset;
    end
  end

  // Layout state: location mask, item count, sticky error, scan pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      count_r <= '0;
      err_r   <= vlv_pkg::ST_OK;
      scan_r  <= '0;
    end else begin
      if (cmd.set_err) begin
        err_r <= cmd.err_ovl ? vlv_pkg::ST_OVERLAP : pre_code;
      end
      if (cmd.record) begin
        used_r[loc_r[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.scan_clr) begin
        scan_r <= '0;
      end else if (cmd.scan_inc) begin
        scan_r <= scan_r + IDX_W'(1);
      end
      if (cmd.emit) begin
        if (done) begin
          used_r  <= '0;
          count_r <= '0;
          err_r   <= vlv_pkg::ST_OK;
        end else begin
          count_r <= count_r + IDX_W'(1);
        end
      end
    end
  end

  // Accepted byte ranges, one entry per attribute position.
  always_ff @(posedge clk) begin
    if (cmd.record) begin
      start_mem[count_r] <= off_r[vlv_pkg::START_W-1:0];
      end_mem[count_r]   <= off_end[vlv_pkg::END_W-1:0];
    end
    if (cmd.rd) begin
      rd_start_r <= start_mem[scan_r];
      rd_end_r   <= end_mem[scan_r];
    end
  end

  // Result register: one strobe per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= err_r;
      out_index_r  <= vlv_pkg::AIDX_W'(count_r);
      out_done_r   <= done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_attr_index  = out_index_r;
  assign out_layout_done = out_done_r;

endmodule

@@ hw/rtl/vlv_checker.sv @@
// Port-level checker for the vertex layout validator, bound to the top level.
`include "vertex_layout_validator_unit_assert.svh"

module vlv_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [vlv_pkg::STATUS_W-1:0] out_status
);

  // A transfer always leaves the unit busy in the next cycle.
  `VLV_ASSERT(a_start_busy, (start && !busy) |=> busy)
  // A result only follows a cycle in which the unit was working.
  `VLV_ASSERT(a_result_after_busy, out_valid |-> $past(busy))
  // One item gives one result strobe, never two in a row.
  `VLV_ASSERT(a_single_strobe, out_valid |=> !out_valid)
  // The reported code never exceeds the overlap code.
  `VLV_ASSERT(a_status_range, out_valid |-> (out_status <= vlv_pkg::ST_OVERLAP))

endmodule

bind vertex_layout_validator_unit vlv_checker u_vlv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status)
);

@@ dv/vertex_layout_validator_unit_tb.sv @@
// Self-checking testbench for the vertex layout validator unit.
module vertex_layout_validator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NATTR = vlv_pkg::MAX_ATTRIBUTES_DEF;
  localparam int NIDX_W = $clog2(NATTR);
  localparam int RAND_ITEMS = 800;

  typedef struct packed {
    logic [vlv_pkg::LOC_W-1:0] loc;
    logic [vlv_pkg::FMT_W-1:0] fmt;
    logic [vlv_pkg::OFF_W-1:0] off;
  } attr_t;

  typedef struct packed {
    logic [vlv_pkg::STATUS_W-1:0] status;
    logic [vlv_pkg::AIDX_W-1:0]   index;
    logic                         done;
  } verdict_t;

  localparam logic [vlv_pkg::FMT_W-1:0] FMT_LIST [5] =
    '{vlv_pkg::FMT_FLOAT1, vlv_pkg::FMT_FLOAT2, vlv_pkg::FMT_FLOAT3,
      vlv_pkg::FMT_FLOAT4, vlv_pkg::FMT_UBYTE4};

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [vlv_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [vlv_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [vlv_pkg::LOC_W-1:0]      in_attr_location = '0;
  logic [vlv_pkg::FMT_W-1:0]      in_attr_format = '0;
  logic [vlv_pkg::OFF_W-1:0]      in_attr_offset = '0;
  logic                           out_valid;
  logic [vlv_pkg::STATUS_W-1:0]   out_status;
  logic [vlv_pkg::AIDX_W-1:0]     out_attr_index;
  logic                           out_layout_done;

  vertex_layout_validator_unit #(.MAX_ATTRIBUTES(NATTR)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_attr_location(in_attr_location),
    .in_attr_format  (in_attr_format),
    .in_attr_offset  (in_attr_offset),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_attr_index  (out_attr_index),
    .out_layout_done (out_layout_done)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Layout predictor state, mirroring the unit's registers and layout memory.
  logic [vlv_pkg::STRIDE_W-1:0] lay_stride = '0;
  logic [vlv_pkg::TOTAL_W-1:0]  lay_total = '0;
  logic [NATTR-1:0]             loc_taken = '0;
  int                           span_lo [NATTR];
  int                           span_hi [NATTR];
  int                           pos = 0;
  logic [vlv_pkg::STATUS_W-1:0] held_err = vlv_pkg::ST_OK;

  attr_t    attr_q [$];
  verdict_t verdict_q [$];
  int       n_queued = 0;
  int       n_accepted = 0;
  int       n_checked = 0;
  int       n_errors = 0;
  int       n_writes = 0;
  int       n_layouts = 0;
  int       n_clean = 0;
  logic [7:0] status_seen = '0;
  bit       took = 1'b0;
  bit       steady = 1'b0;

  function automatic int attr_bytes(input logic [vlv_pkg::FMT_W-1:0] fmt);
    case (fmt)
      vlv_pkg::FMT_FLOAT1, vlv_pkg::FMT_UBYTE4: return 4;
      vlv_pkg::FMT_FLOAT2: return 8;
      vlv_pkg::FMT_FLOAT3: return 12;
      vlv_pkg::FMT_FLOAT4: return 16;
      default: return 0;
    endcase
  endfunction

  // Advances the layout state by one attribute and returns the verdict it yields.
  function automatic verdict_t judge_attr(input attr_t a);
    int p, sz, o, s, j;
    logic [vlv_pkg::STATUS_W-1:0] code;
    verdict_t v;
    p = (pos >= NATTR) ? NATTR - 1 : pos;
    sz = attr_bytes(a.fmt);
    o = int'(a.off);
    s = int'(lay_stride);
    if (held_err == vlv_pkg::ST_OK) begin
      code = vlv_pkg::ST_OK;
      if (s == 0 || s > int'(vlv_pkg::STRIDE_MAX) || s % 4 != 0) begin
        code = vlv_pkg::ST_STRIDE;
      end else if (lay_total == 0 || int'(lay_total) > NATTR) begin
        code = vlv_pkg::ST_COUNT;
      end else if (p == 0 &&
                   (a.loc != 0 || a.fmt != vlv_pkg::FMT_FLOAT3 || o != 0)) begin
        code = vlv_pkg::ST_FIRST;
      end else if (int'(a.loc) >= NATTR || sz == 0 || o % 4 != 0 || o > s ||
                   sz > s - o) begin
        code = vlv_pkg::ST_ATTR;
      end else if (loc_taken[a.loc[NIDX_W-1:0]]) begin
        code = vlv_pkg::ST_ATTR;
      end else begin
        for (j = 0; j < p; j++) begin
          if (o < span_hi[j] && span_lo[j] < o + sz) code = vlv_pkg::ST_OVERLAP;
        end
      end
      if (code == vlv_pkg::ST_OK) begin
        loc_taken[a.loc[NIDX_W-1:0]] = 1'b1;
        span_lo[p] = o;
        span_hi[p] = o + sz;
      end
      held_err = code;
    end
    v.status = held_err;
    v.index = p[vlv_pkg::AIDX_W-1:0];
    v.done = (lay_total == 0) || (p + 1 == int'(lay_total)) || (p == NATTR - 1);
    if (v.done) begin
      loc_taken = '0;
      pos = 0;
      held_err = vlv_pkg::ST_OK;
    end else begin
      pos = p + 1;
    end
    return v;
  endfunction

  // Observes register writes, attribute transfers and results.
  always @(posedge clk) begin
    verdict_t got, want;
    took = rst_n && start && !busy;
    if (rst_n && cfg_we) begin
      case (cfg_addr)
        vlv_pkg::REG_STRIDE: lay_stride = cfg_wdata;
        vlv_pkg::REG_ATTR_TOTAL: lay_total = cfg_wdata[vlv_pkg::TOTAL_W-1:0];
        default: ;
      endcase
    end
    if (rst_n && out_valid) begin
      got = '{out_status, out_attr_index, out_layout_done};
      if (verdict_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 50)
          $display("%0t: result with none expected: status %0d index %0d done %0b",
                   $time, got.status, got.index, got.done);
      end else begin
        want = verdict_q.pop_front();
        n_checked++;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 50)
            $display("%0t: expected status %0d index %0d done %0b, got status %0d index %0d done %0b",
                     $time, want.status, want.index, want.done,
                     got.status, got.index, got.done);
        end
        if (want.done) begin
          n_layouts++;
          if (want.status == vlv_pkg::ST_OK) n_clean++;
        end
        status_seen[want.status] = 1'b1;
      end
    end
    if (took) begin
      verdict_q.push_back(judge_attr('{in_attr_location, in_attr_format, in_attr_offset}));
      n_accepted++;
    end
  end

  // Sender: offers queued attributes in bursts separated by random gaps.
  always @(negedge clk) begin
    static int burst_left = 0;
    static int gap_left = 0;
    attr_t a;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // Hold the offered attribute until the transfer.
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (attr_q.size() > 0) begin
      a = attr_q.pop_front();
      start <= 1'b1;
      in_attr_location <= a.loc;
      in_attr_format <= a.fmt;
      in_attr_offset <= a.off;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 12);
        if (steady) gap_left = 0;
        else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(10, 40);
        else gap_left = $urandom_range(1, 6);
      end
    end else begin
      start <= 1'b0;
    end
  end

  task automatic add_item(input logic [vlv_pkg::LOC_W-1:0] loc,
                          input logic [vlv_pkg::FMT_W-1:0] fmt,
                          input logic [vlv_pkg::OFF_W-1:0] off);
    attr_q.push_back('{loc, fmt, off});
    n_queued++;
  endtask

  // Waits until every attribute has been transferred and answered.
  task automatic settle();
    while (n_accepted != n_queued || verdict_q.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [vlv_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [vlv_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_writes++;
  endtask

  // Queues well-formed layouts from the current layout position, with a share
  // of corrupted attributes; stops early after cap attributes.
  task automatic compose_layouts(input int n_lay, input int cap, input int noise_pct);
    int p, c, r, k, emitted;
    logic [NATTR-1:0] m;
    logic [vlv_pkg::LOC_W-1:0] loc;
    logic [vlv_pkg::FMT_W-1:0] fmt;
    logic [vlv_pkg::OFF_W-1:0] off;
    p = pos;
    m = loc_taken;
    c = 0;
    emitted = 0;
    for (k = 0; k < p && k < NATTR; k++) if (span_hi[k] > c) c = span_hi[k];
    while (n_lay > 0 && emitted < cap) begin
      if (p == 0) begin
        loc = '0;
        fmt = vlv_pkg::FMT_FLOAT3;
        off = '0;
      end else begin
        r = $urandom_range(0, NATTR - 1);
        for (k = 0; k < NATTR && m[(r + k) % NATTR]; k++) ;
        loc = vlv_pkg::LOC_W'((r + k) % NATTR);
        fmt = FMT_LIST[$urandom_range(0, 4)];
        off = vlv_pkg::OFF_W'(c + (($urandom_range(0, 3) == 0) ?
                                   4 * int'($urandom_range(1, 4)) : 0));
      end
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 5))
          0: loc = vlv_pkg::LOC_W'($urandom);
          1: fmt = vlv_pkg::FMT_W'($urandom);
          2: off = vlv_pkg::OFF_W'($urandom);
          3: off = vlv_pkg::OFF_W'(4 * int'($urandom_range(0, c / 4)));
          4: off = vlv_pkg::OFF_W'(int'(lay_stride) - attr_bytes(fmt) +
                                   4 * int'($urandom_range(0, 1)));
          default: loc = vlv_pkg::LOC_W'($urandom_range(0, NATTR - 1));
        endcase
      end
      add_item(loc, fmt, off);
      emitted++;
      if (int'(loc) < NATTR) m[loc[NIDX_W-1:0]] = 1'b1;
      if (int'(off) + attr_bytes(fmt) > c) c = int'(off) + attr_bytes(fmt);
      if (lay_total == 0 || p + 1 == int'(lay_total) || p == NATTR - 1) begin
        p = 0;
        m = '0;
        c = 0;
        n_lay--;
      end else begin
        p++;
      end
    end
  endtask

  initial begin
    int k, sel;
    logic [vlv_pkg::STRIDE_W-1:0] s;
    logic [vlv_pkg::TOTAL_W-1:0] t;
    logic [7:0] pad;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers still at their reset values: stride error on a one-item layout.
    add_item('1, '1, '1);
    settle();

    // A full, clean layout at the largest stride, the last attribute ending
    // exactly at the stride.
    write_reg(vlv_pkg::REG_STRIDE, vlv_pkg::STRIDE_MAX);
    write_reg(vlv_pkg::REG_ATTR_TOTAL, vlv_pkg::CFG_DATA_W'(NATTR));
    add_item('0, vlv_pkg::FMT_FLOAT3, '0);
    for (k = 1; k < NATTR - 1; k++)
      add_item(vlv_pkg::LOC_W'(NATTR - k), FMT_LIST[k % 5],
               vlv_pkg::OFF_W'(12 + 16 * (k - 1)));
    add_item(8'd1, vlv_pkg::FMT_FLOAT4, vlv_pkg::STRIDE_MAX - 16'd16);
    settle();

    // Unsupported format on the top location with an out-of-range offset.
    write_reg(vlv_pkg::REG_STRIDE, 16'd12);
    write_reg(vlv_pkg::REG_ATTR_TOTAL, 16'd2);
    add_item('0, vlv_pkg::FMT_FLOAT3, '0);
    add_item(vlv_pkg::LOC_W'(NATTR - 1), '1, 16'hFFFC);
    settle();

    // Overlap on the second attribute, then held for the rest of the layout.
    write_reg(vlv_pkg::REG_STRIDE, 16'd24);
    write_reg(vlv_pkg::REG_ATTR_TOTAL, 16'd3);
    add_item('0, vlv_pkg::FMT_FLOAT3, '0);
    add_item(8'd1, vlv_pkg::FMT_FLOAT2, 16'd8);
    add_item(8'd2, vlv_pkg::FMT_FLOAT1, 16'd16);
    settle();

    // First attribute not in its canonical form.
    write_reg(vlv_pkg::REG_STRIDE, 16'd16);
    write_reg(vlv_pkg::REG_ATTR_TOTAL, 16'd2);
    add_item('0, vlv_pkg::FMT_FLOAT3, 16'd4);
    add_item(8'd1, vlv_pkg::FMT_FLOAT1, 16'd12);

    while (n_queued < RAND_ITEMS + 24) begin
      settle();
      case ($urandom_range(0, 9))
        0: s = vlv_pkg::STRIDE_MAX;
        1: s = 16'd4;
        2: s = 16'd12;
        3: s = vlv_pkg::STRIDE_W'($urandom);
        4: begin
          case ($urandom_range(0, 3))
            0: s = '0;
            1: s = '1;
            2: s = vlv_pkg::STRIDE_MAX + 16'd4;
            default: s = vlv_pkg::STRIDE_W'(4 * $urandom_range(3, 512) +
                                            $urandom_range(1, 3));
          endcase
        end
        5: s = vlv_pkg::STRIDE_W'(4 * $urandom_range(1, 40));
        default: s = vlv_pkg::STRIDE_W'(4 * $urandom_range(16, 512));
      endcase
      case ($urandom_range(0, 9))
        0: t = 8'd1;
        1: t = vlv_pkg::TOTAL_W'(NATTR);
        2: t = '0;
        3: t = vlv_pkg::TOTAL_W'($urandom_range(NATTR + 1, 255));
        default: t = vlv_pkg::TOTAL_W'($urandom_range(1, NATTR));
      endcase
      pad = 8'($urandom);
      sel = $urandom_range(0, 5);
      if (sel != 0) write_reg(vlv_pkg::REG_STRIDE, s);
      if (sel != 1) write_reg(vlv_pkg::REG_ATTR_TOTAL, {pad, t});
      steady = ($urandom_range(0, 4) == 0);
      // A truncated phase leaves the layout open across the next register write.
      compose_layouts($urandom_range(1, 3),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 1000,
                      ($urandom_range(0, 5) == 0) ? 60 : 8);
    end

    settle();
    repeat (30) @(posedge clk);
    $display("Checked %0d attribute results over %0d register writes.", n_checked, n_writes);
    $display("Closed %0d layouts, %0d clean; status codes seen (bit per code): %b.",
             n_layouts, n_clean, status_seen);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(3_000_000);
    $display("Timed out waiting for the unit.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
